/* design/ruci_pkg.sv */
// ----------------------------------------------------------------------------
// Ray unit cube intersection: shared package
// Field widths, face codes, register indexes and the per-face result types.
// ----------------------------------------------------------------------------
`default_nettype none

package ruci_pkg;

    // Field widths.
    localparam int COORD_W   = 32;
    localparam int DIST_W    = 31;
    localparam int CFG_W     = 16;
    localparam int NUM_FACES = 6;

    // Face codes, in test order.
    localparam logic [2:0] FACE_POS_X = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Z = 3'd4;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;

    // Register indexes and reset values.
    localparam logic REG_MIN_DISTANCE   = 1'b0;
    localparam logic REG_EDGE_TOLERANCE = 1'b1;

    localparam logic [CFG_W-1:0] MIN_DISTANCE_RST   = 16'd1;
    localparam logic [CFG_W-1:0] EDGE_TOLERANCE_RST = 16'd1;

    // Distance of one face as it leaves the divider.
    typedef struct packed {
        logic              ok;
        logic [DIST_W-1:0] t;
    } face_dist_t;

    // Distance and bounds verdict of one face.
    typedef struct packed {
        logic              ok;
        logic              in_bounds;
        logic [DIST_W-1:0] t;
    } face_res_t;

endpackage

`default_nettype wire

/* design/ray_unit_cube_intersect_core.sv */
// ----------------------------------------------------------------------------
// Ray unit cube intersection core
// Intersects a ray with the faces of the cube from -1 to 1 on every axis and
// returns the nearest accepted face nearer than the given best distance.
//
//   Channel   Handshake            Payload
//   input     in_valid / in_ready  origin_x..z, dir_x..z, best_distance
//   output    out_valid / ready    hit, hit_distance, hit_face
//   config    APB, pready high     min_distance @0x0, edge_tolerance @0x4
//
// One item enters per cycle while the output is not stalled; each item passes
// the one-bit-per-stage divider, two bounds stages and the output register.
// A stall at the output halts the whole pipeline, nothing is lost or
// repeated. Reset clears the valid bits and sets both registers to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_unit_cube_intersect_core #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] origin_x,
    input  wire logic [31:0] origin_y,
    input  wire logic [31:0] origin_z,
    input  wire logic [31:0] dir_x,
    input  wire logic [31:0] dir_y,
    input  wire logic [31:0] dir_z,
    input  wire logic [30:0] best_distance,
    // Output channel
    output logic             out_valid,
    input  wire logic        ready,
    output logic             hit,
    output logic      [30:0] hit_distance,
    output logic      [2:0]  hit_face,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int CW      = ruci_pkg::COORD_W;
    localparam int NF      = ruci_pkg::NUM_FACES;
    localparam int DIV_LAT = ruci_pkg::DIST_W + 1;
    localparam int CHK_LAT = 2;
    localparam int LAT     = DIV_LAT + CHK_LAT;

    logic [ruci_pkg::CFG_W-1:0] min_distance_reg;
    logic [ruci_pkg::CFG_W-1:0] edge_tolerance_reg;
    logic                       cfg_wr;

    logic                       advance;
    logic                       sel_valid;
    logic                       valid_reg [LAT];

    logic signed [CW-1:0]       org_in  [3];
    logic signed [CW-1:0]       dir_in  [3];
    logic signed [CW-1:0]       org_dly [3];
    logic signed [CW-1:0]       dir_dly [3];
    logic [6*CW-1:0]            ray_dly;
    logic [ruci_pkg::DIST_W-1:0] best_dly;

    ruci_pkg::face_dist_t       face_dist [NF];
    ruci_pkg::face_res_t        fres      [NF];

    // Configuration registers.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_distance_reg   <= ruci_pkg::MIN_DISTANCE_RST;
            edge_tolerance_reg <= ruci_pkg::EDGE_TOLERANCE_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                ruci_pkg::REG_MIN_DISTANCE:   min_distance_reg   <= pwdata[15:0];
                ruci_pkg::REG_EDGE_TOLERANCE: edge_tolerance_reg <= pwdata[15:0];
                default:                      min_distance_reg   <= min_distance_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            ruci_pkg::REG_MIN_DISTANCE:   prdata = {16'b0, min_distance_reg};
            ruci_pkg::REG_EDGE_TOLERANCE: prdata = {16'b0, edge_tolerance_reg};
            default:                      prdata = '0;
        endcase
    end

    // The pipeline moves whenever the output register is free or being taken.
    assign advance  = !sel_valid || ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    assign org_in[0] = origin_x;
    assign org_in[1] = origin_y;
    assign org_in[2] = origin_z;
    assign dir_in[0] = dir_x;
    assign dir_in[1] = dir_y;
    assign dir_in[2] = dir_z;

    // The ray travels alongside the dividers, the best distance alongside the dividers and bounds checks.
    ruci_delay #(.WIDTH(6*CW), .DEPTH(DIV_LAT)) u_ray_dly (
        .clk  (clk),
        .en   (advance),
        .din  ({origin_x, origin_y, origin_z, dir_x, dir_y, dir_z}),
        .dout (ray_dly)
    );

    ruci_delay #(.WIDTH(ruci_pkg::DIST_W), .DEPTH(LAT)) u_best_dly (
        .clk  (clk),
        .en   (advance),
        .din  (best_distance),
        .dout (best_dly)
    );

    assign org_dly[0] = ray_dly[6*CW-1:5*CW];
    assign org_dly[1] = ray_dly[5*CW-1:4*CW];
    assign org_dly[2] = ray_dly[4*CW-1:3*CW];
    assign dir_dly[0] = ray_dly[3*CW-1:2*CW];
    assign dir_dly[1] = ray_dly[2*CW-1:CW];
    assign dir_dly[2] = ray_dly[CW-1:0];

    // One divider and one bounds check per face.
    for (genvar f = 0; f < NF; f++)
    begin : g_face
        ruci_div #(.FRAC_BITS(FRAC_BITS), .NEG_FACE((f % 2) == 1)) u_div (
            .clk    (clk),
            .en     (advance),
            .origin (org_in[f/2]),
            .dir    (dir_in[f/2]),
            .res    (face_dist[f])
        );

        ruci_face_chk #(.FRAC_BITS(FRAC_BITS)) u_chk (
            .clk            (clk),
            .en             (advance),
            .origin         (org_dly),
            .dir            (dir_dly),
            .face_dist      (face_dist[f]),
            .edge_tolerance (edge_tolerance_reg),
            .res            (fres[f])
        );
    end

    ruci_select u_select (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (advance),
        .valid_in      (valid_reg[LAT-1]),
        .res           (fres),
        .best_distance (best_dly),
        .min_distance  (min_distance_reg),
        .out_valid     (sel_valid),
        .hit           (hit),
        .hit_distance  (hit_distance),
        .hit_face      (hit_face)
    );

    assign out_valid = sel_valid;

endmodule

`default_nettype wire

/* design/ruci_delay.sv */
// ----------------------------------------------------------------------------
// Ray unit cube intersection: alignment delay line
// A chain of registers that carries payload alongside the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module ruci_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // Each tap moves one place along when the pipeline advances.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

/* design/ruci_div.sv */
// ----------------------------------------------------------------------------
// Ray unit cube intersection: face distance divider
// Pipelined restoring divider giving t = (plane - o) * 2^F / d, one quotient
// bit per stage, with rejection of non-positive and out-of-range distances.
// ----------------------------------------------------------------------------
`default_nettype none

module ruci_div #(
    parameter int FRAC_BITS = 24,
    parameter bit NEG_FACE  = 1'b0
) (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic signed [ruci_pkg::COORD_W-1:0] origin,
    input  wire logic signed [ruci_pkg::COORD_W-1:0] dir,
    output ruci_pkg::face_dist_t                     res
);

    localparam int QB    = ruci_pkg::DIST_W;
    localparam int CW    = ruci_pkg::COORD_W;
    localparam int NUM_W = ((FRAC_BITS + 2 > CW + 1) ? FRAC_BITS + 2 : CW + 1) + 1;
    localparam int CMP_W = (NUM_W + FRAC_BITS > 64) ? NUM_W + FRAC_BITS : 64;
    localparam int REM_W = CMP_W;

    logic signed [NUM_W-1:0] one_c;
    logic signed [NUM_W-1:0] num_c;
    logic        [NUM_W-1:0] num_mag_c;
    logic        [CW-1:0]    dir_mag_c;
    logic        [CMP_W-1:0] dividend_c;
    logic        [CMP_W-1:0] limit_c;
    logic                    ok_c;

    logic [REM_W-1:0] rem_reg [QB+1];
    logic [CW-1:0]    dsr_reg [QB+1];
    logic [QB-1:0]    q_reg   [QB+1];
    logic             ok_reg  [QB+1];

    // Numerator, magnitudes and the range check on the whole quotient.
    always_comb
    begin
        one_c      = {{(NUM_W-1){1'b0}}, 1'b1} << FRAC_BITS;
        num_c      = (NEG_FACE ? -one_c : one_c) - NUM_W'(origin);
        num_mag_c  = num_c[NUM_W-1] ? NUM_W'(-num_c) : NUM_W'(num_c);
        dir_mag_c  = dir[CW-1] ? CW'(-dir) : CW'(dir);
        dividend_c = CMP_W'(num_mag_c) << FRAC_BITS;
        limit_c    = CMP_W'(dir_mag_c) << QB;
        ok_c       = (num_c != '0) && (dir != '0) && (num_c[NUM_W-1] == dir[CW-1])
                     && (dividend_c < limit_c);
    end

    // Entry stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= dividend_c[REM_W-1:0];
            dsr_reg[0] <= dir_mag_c;
            q_reg[0]   <= '0;
            ok_reg[0]  <= ok_c;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 0; j < QB; j++)
    begin : g_bit
        localparam int SH = QB - 1 - j;
        logic [REM_W-1:0] diff_c;
        logic             take_c;

        assign diff_c = rem_reg[j] - (REM_W'(dsr_reg[j]) << SH);
        assign take_c = ~diff_c[REM_W-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= take_c ? diff_c : rem_reg[j];
                dsr_reg[j+1] <= dsr_reg[j];
                q_reg[j+1]   <= {q_reg[j][QB-2:0], take_c};
                ok_reg[j+1]  <= ok_reg[j];
            end
        end
    end

    assign res.ok = ok_reg[QB];
    assign res.t  = q_reg[QB];

endmodule

`default_nettype wire

/* design/ruci_face_chk.sv */
// ----------------------------------------------------------------------------
// Ray unit cube intersection: face bounds check
// Two stages: hit point products, then the widened cube bounds test.
// ----------------------------------------------------------------------------
`default_nettype none

module ruci_face_chk #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic signed [ruci_pkg::COORD_W-1:0] origin [3],
    input  wire logic signed [ruci_pkg::COORD_W-1:0] dir    [3],
    input  wire ruci_pkg::face_dist_t                face_dist,
    input  wire logic        [ruci_pkg::CFG_W-1:0]   edge_tolerance,
    output ruci_pkg::face_res_t                      res
);

    localparam int CW  = ruci_pkg::COORD_W;
    localparam int HA  = (65 - FRAC_BITS > CW + 2) ? 65 - FRAC_BITS : CW + 2;
    localparam int HW  = (HA > FRAC_BITS + 3) ? HA : FRAC_BITS + 3;

    logic signed [63:0]   prod_reg [3];
    logic signed [CW-1:0] org_reg  [3];
    ruci_pkg::face_dist_t dist_reg;
    ruci_pkg::face_res_t  res_reg;

    logic signed [HW-1:0] bound_c;
    logic signed [HW-1:0] h_c [3];
    logic                 inside_c;

    // Products of direction and distance.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= dir[k] * $signed({1'b0, face_dist.t});
                org_reg[k]  <= origin[k];
            end
            dist_reg <= face_dist;
        end
    end

    // Hit point with floor shift, compared against the widened bounds.
    always_comb
    begin
        bound_c  = ({{(HW-1){1'b0}}, 1'b1} << FRAC_BITS) + HW'(edge_tolerance);
        inside_c = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            h_c[k] = HW'(org_reg[k]) + HW'(prod_reg[k] >>> FRAC_BITS);
            if ((h_c[k] < -bound_c) || (h_c[k] > bound_c))
            begin
                inside_c = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.ok        <= dist_reg.ok;
            res_reg.in_bounds <= inside_c;
            res_reg.t         <= dist_reg.t;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

/* design/ruci_select.sv */
// ----------------------------------------------------------------------------
// Ray unit cube intersection: nearest face selection
// Walks the six faces in order, keeps the nearest accepted one and holds the
// result item in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ruci_select (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              valid_in,
    input  wire ruci_pkg::face_res_t               res [ruci_pkg::NUM_FACES],
    input  wire logic [ruci_pkg::DIST_W-1:0]       best_distance,
    input  wire logic [ruci_pkg::CFG_W-1:0]        min_distance,
    output logic                                   out_valid,
    output logic                                   hit,
    output logic      [ruci_pkg::DIST_W-1:0]       hit_distance,
    output logic      [2:0]                        hit_face
);

    logic                          hit_c;
    logic [ruci_pkg::DIST_W-1:0]   best_c;
    logic [2:0]                    face_c;

    logic                          out_valid_reg;
    logic                          hit_reg;
    logic [ruci_pkg::DIST_W-1:0]   dist_reg;
    logic [2:0]                    face_reg;

    // An accepted face becomes the new best, so a tie keeps the earlier face.
    always_comb
    begin
        hit_c  = 1'b0;
        best_c = best_distance;
        face_c = ruci_pkg::FACE_POS_X;
        for (int f = 0; f < ruci_pkg::NUM_FACES; f++)
        begin
            if (res[f].ok && res[f].in_bounds
                && (res[f].t > ruci_pkg::DIST_W'(min_distance)) && (res[f].t < best_c))
            begin
                hit_c  = 1'b1;
                best_c = res[f].t;
                face_c = 3'(f);
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= hit_c;
            dist_reg <= best_c;
            face_reg <= face_c;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign hit_distance = dist_reg;
    assign hit_face     = face_reg;

endmodule

`default_nettype wire

/* tb/sv/ruci_checker.sv */
// ----------------------------------------------------------------------------
// Ray unit cube intersection: result checker
// Watches the input, output and register channels of the core. It predicts
// the nearest accepted face for every accepted ray and compares each
// accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module ruci_checker #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [31:0] origin_x,
    input  wire logic [31:0] origin_y,
    input  wire logic [31:0] origin_z,
    input  wire logic [31:0] dir_x,
    input  wire logic [31:0] dir_y,
    input  wire logic [31:0] dir_z,
    input  wire logic [30:0] best_distance,
    input  wire logic        out_valid,
    input  wire logic        ready,
    input  wire logic        hit,
    input  wire logic [30:0] hit_distance,
    input  wire logic [2:0]  hit_face,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               fail_count,
    output int               pending_hits
);

    typedef struct {
        logic                        hit;
        logic [ruci_pkg::DIST_W-1:0] distance;
        logic [2:0]                  face;
    } cube_hit_t;

    cube_hit_t                  expected_hits[$];
    logic [ruci_pkg::CFG_W-1:0] min_dist_q;
    logic [ruci_pkg::CFG_W-1:0] edge_tol_q;

    // Nearest accepted face for one ray under the given register values.
    function automatic cube_hit_t nearest_face(
        input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
        input logic [31:0] dx, input logic [31:0] dy, input logic [31:0] dz,
        input logic [ruci_pkg::DIST_W-1:0] best_in,
        input logic [ruci_pkg::CFG_W-1:0] min_d, input logic [ruci_pkg::CFG_W-1:0] tol);
        longint    org[3];
        longint    dir[3];
        longint    one;
        longint    lo;
        longint    hi;
        longint    num;
        longint    n_abs;
        longint    d_abs;
        longint    t;
        longint    best;
        longint    pt;
        bit        in_bounds;
        int        ax;
        cube_hit_t res;
        org[0] = longint'(signed'(ox));
        org[1] = longint'(signed'(oy));
        org[2] = longint'(signed'(oz));
        dir[0] = longint'(signed'(dx));
        dir[1] = longint'(signed'(dy));
        dir[2] = longint'(signed'(dz));
        one  = longint'(1) << FRAC_BITS;
        lo   = -one - longint'(tol);
        hi   = one + longint'(tol);
        best = longint'(best_in);
        res.hit  = 1'b0;
        res.face = ruci_pkg::FACE_POS_X;
        for (int f = 0; f < ruci_pkg::NUM_FACES; f++)
        begin
            ax  = f >> 1;
            num = ((f & 1) != 0) ? -one - org[ax] : one - org[ax];
            // A zero direction, a zero distance or a distance on the wrong side is skipped.
            if (dir[ax] == 0 || num == 0)
                continue;
            if ((num < 0) != (dir[ax] < 0))
                continue;
            n_abs = (num < 0) ? -num : num;
            d_abs = (dir[ax] < 0) ? -dir[ax] : dir[ax];
            t = (n_abs << FRAC_BITS) / d_abs;
            if (t >= 64'h8000_0000)
                continue;
            if (!(t < best && t > longint'(min_d)))
                continue;
            // The hit point must lie within the widened cube.
            in_bounds = 1'b1;
            for (int k = 0; k < 3; k++)
            begin
                pt = org[k] + ((dir[k] * t) >>> FRAC_BITS);
                if (pt < lo || pt > hi)
                    in_bounds = 1'b0;
            end
            if (in_bounds)
            begin
                best     = t;
                res.face = 3'(f);
                res.hit  = 1'b1;
            end
        end
        res.distance = best[ruci_pkg::DIST_W-1:0];
        return res;
    endfunction

    assign pending_hits = expected_hits.size();

    // Shadow registers follow completed writes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_q <= ruci_pkg::MIN_DISTANCE_RST;
            edge_tol_q <= ruci_pkg::EDGE_TOLERANCE_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == ruci_pkg::REG_MIN_DISTANCE)
                min_dist_q <= pwdata[ruci_pkg::CFG_W-1:0];
            else
                edge_tol_q <= pwdata[ruci_pkg::CFG_W-1:0];
        end
    end

    // Predict on each accepted ray and check each accepted result.
    initial fail_count = 0;
    always @(posedge clk)
    begin
        cube_hit_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_hits.push_back(nearest_face(origin_x, origin_y, origin_z,
                    dir_x, dir_y, dir_z, best_distance, min_dist_q, edge_tol_q));
            if (out_valid && ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("result with no ray outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, hit);
                        fail_count++;
                    end
                    if (hit_distance !== want.distance)
                    begin
                        $error("hit_distance: expected %0d, got %0d",
                               want.distance, hit_distance);
                        fail_count++;
                    end
                    if (hit_face !== want.face)
                    begin
                        $error("hit_face: expected %0d, got %0d", want.face, hit_face);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// Ray unit cube intersection: testbench top
// Drives directed and random rays into the core under several register
// settings, with random gaps and output stalls, and reports the verdict from
// the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int ONE       = 32'sh0100_0000;
    localparam int LATENCY   = 35;
    localparam int MAX_CYC   = 2_000_000;
    localparam int HOLD_CYC  = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] origin_x = '0;
    logic [31:0] origin_y = '0;
    logic [31:0] origin_z = '0;
    logic [31:0] dir_x = '0;
    logic [31:0] dir_y = '0;
    logic [31:0] dir_z = '0;
    logic [30:0] best_distance = '0;
    logic        out_valid;
    logic        ready = 1'b0;
    logic        hit;
    logic [30:0] hit_distance;
    logic [2:0]  hit_face;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending_hits;
    int ready_pct = 100;
    int gap_pct = 0;
    bit hold_req = 1'b0;
    int cycle_count = 0;

    always #6 clk = ~clk;

    ray_unit_cube_intersect_core u_dut (.*);

    ruci_checker u_chk (.*);

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYC)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Output side: random stalls, rare long ones, and one long hold-off on request.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge clk);
                hold_req = 1'b0;
            end
            else if ($urandom_range(0, 199) == 0 && ready_pct < 100)
            begin
                ready <= 1'b0;
                repeat ($urandom_range(20, 80)) @(posedge clk);
            end
            else
                ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    // Register write: setup cycle then access cycle.
    task automatic write_reg(input logic idx, input logic [ruci_pkg::CFG_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait until every predicted result has arrived and the pipe has emptied.
    // The first edge lets the checker record the last accepted ray.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_hits != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic set_limits(input logic [ruci_pkg::CFG_W-1:0] min_d,
                              input logic [ruci_pkg::CFG_W-1:0] tol);
        drain();
        write_reg(ruci_pkg::REG_MIN_DISTANCE, min_d);
        write_reg(ruci_pkg::REG_EDGE_TOLERANCE, tol);
    endtask

    // Offer one ray and hold it until accepted, then maybe leave a gap.
    task automatic send_ray(input int ox, input int oy, input int oz,
                            input int dx, input int dy, input int dz,
                            input logic [30:0] best);
        int r;
        in_valid      <= 1'b1;
        origin_x      <= ox;
        origin_y      <= oy;
        origin_z      <= oz;
        dir_x         <= dx;
        dir_y         <= dy;
        dir_z         <= dz;
        best_distance <= best;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = $urandom_range(0, 99);
        if (r < gap_pct)
        begin
            in_valid <= 1'b0;
            if (r < gap_pct / 10)
                repeat ($urandom_range(20, 60)) @(posedge clk);
            else
                repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    function automatic int rand_span(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Random ray: mostly aimed near the cube, some pure noise.
    task automatic send_random_ray();
        int org[3];
        int aim[3];
        int dir[3];
        int sh;
        int sel;
        logic [30:0] best;
        sel = $urandom_range(0, 99);
        if (sel < 12)
        begin
            send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     31'($urandom));
            return;
        end
        sh = $urandom_range(0, 5);
        for (int k = 0; k < 3; k++)
        begin
            org[k] = rand_span(4 * ONE);
            if ($urandom_range(0, 9) == 0)
                aim[k] = ($urandom_range(0, 1) ? ONE : -ONE) + rand_span(4);
            else
                aim[k] = rand_span(ONE + ONE / 4);
            dir[k] = (aim[k] - org[k]) >>> sh;
            if ($urandom_range(0, 11) == 0)
                dir[k] = 0;
        end
        if (sel < 60)
            best = 31'h7FFF_FFFF - 31'($urandom_range(0, 255));
        else if (sel < 85)
            best = 31'($urandom_range(0, 8 * ONE));
        else
            best = 31'($urandom);
        send_ray(org[0], org[1], org[2], dir[0], dir[1], dir[2], best);
    endtask

    task automatic random_phase(input int count);
        repeat (count) send_random_ray();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rays under the reset register values.
        send_ray(2 * ONE, 0, 0, -ONE, 0, 0, 31'h7FFF_FFFF);       // +x face
        send_ray(-2 * ONE, 0, 0, ONE, 0, 0, 31'h7FFF_FFFF);       // -x face
        send_ray(0, 3 * ONE, 0, 0, -ONE, 0, 31'h7FFF_FFFF);       // +y face
        send_ray(0, -3 * ONE, 0, 0, ONE, 0, 31'h7FFF_FFFF);       // -y face
        send_ray(0, 0, 2 * ONE, 0, 0, -ONE, 31'h7FFF_FFFF);       // +z face
        send_ray(0, 0, -2 * ONE, 0, 0, ONE, 31'h7FFF_FFFF);       // -z face
        send_ray(2 * ONE, 2 * ONE, 0, -ONE, -ONE, 0, 31'h7FFF_FFFF); // corner tie
        send_ray(2 * ONE, 0, 0, -ONE, 0, 0, 31'(ONE));            // hit exactly at best
        send_ray(2 * ONE, 0, 0, -ONE, 0, 0, 31'(ONE - 1));        // best just short
        send_ray(2 * ONE, 0, 0, ONE, 0, 0, 31'h7FFF_FFFF);        // pointing away
        send_ray(0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF);                // all directions zero
        send_ray(0, 0, 0, ONE, ONE / 2, -ONE / 4, 31'h7FFF_FFFF); // from inside
        send_ray(ONE, 0, 0, ONE, 0, 0, 31'h7FFF_FFFF);            // origin on a face
        send_ray(2 * ONE, 0, 0, -1, 0, 0, 31'h7FFF_FFFF);         // distance too far
        send_ray(2 * ONE, ONE + 1, 0, -ONE, 0, 0, 31'h7FFF_FFFF); // edge within slack
        send_ray(2 * ONE, ONE + 2, 0, -ONE, 0, 0, 31'h7FFF_FFFF); // edge past slack
        send_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
        send_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF);
        send_ray(2 * ONE, 0, 0, -ONE, 0, 0, 31'd0);               // best of zero
        send_ray(ONE + 1, 0, 0, -ONE, 0, 0, 31'h7FFF_FFFF);       // distance of one LSB
        send_ray(ONE + 2, 0, 0, -ONE, 0, 0, 31'h7FFF_FFFF);       // just above minimum

        // Extreme limits: nothing below min, widest slack.
        set_limits(16'hFFFF, 16'hFFFF);
        send_ray(ONE + 16'hFFFF, 0, 0, -ONE, 0, 0, 31'h7FFF_FFFF);
        send_ray(ONE + 32'h1_0000, 0, 0, -ONE, 0, 0, 31'h7FFF_FFFF);
        send_ray(2 * ONE, ONE + 16'hFFFF, 0, -ONE, 0, 0, 31'h7FFF_FFFF);
        gap_pct   = 20;
        ready_pct = 70;
        random_phase(400);

        // Zero limits, with a long output hold-off while rays keep coming.
        set_limits(16'd0, 16'd0);
        hold_req = 1'b1;
        random_phase(400);

        // Random limits, no idling on either side.
        set_limits(16'($urandom), 16'($urandom));
        gap_pct   = 0;
        ready_pct = 100;
        random_phase(300);

        // Mixed extremes; the sender pauses until everything is back mid-phase.
        set_limits(16'd0, 16'hFFFF);
        gap_pct   = 30;
        ready_pct = 50;
        random_phase(200);
        drain();
        random_phase(200);

        // Back to the reset values.
        set_limits(ruci_pkg::MIN_DISTANCE_RST, ruci_pkg::EDGE_TOLERANCE_RST);
        gap_pct   = 10;
        ready_pct = 85;
        random_phase(500);

        drain();
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire
